// File: rtl/core/olidm_pkg.sv
// Shared constants, codes and control types of the ordered list block.
package olidm_pkg;

  localparam int unsigned CAPACITY_DEF      = 256;
  localparam int unsigned FRACTION_BITS_DEF = 14;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned AVG_W       = 46;
  localparam int unsigned COUNT_OUT_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_AVERAGE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

  localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_INS_FIN,
    ST_DEL_FIN,
    ST_DIV,
    ST_ROUND,
    ST_SAT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                accept;
    logic                status_we;
    logic [STATUS_W-1:0] status_code;
    logic                setup_ins;
    logic                setup_del;
    logic                shift;
    logic                ins_fin;
    logic                del_fin;
    logic                div_start;
    logic                div_step;
    logic                round;
    logic                sat;
    logic                respond;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pos_zero;
    logic              pos_beyond;
    logic              full;
    logic              empty;
    logic              shift_done;
    logic              div_last;
    logic              out_busy;
  } stat_t;

endpackage

// File: rtl/core/olidm_if.sv
// Request and response channel interfaces of the ordered list block.
interface olidm_req_if;
  logic                                valid;
  logic                                ready;
  logic [olidm_pkg::FUNC_W-1:0]        func;
  logic signed [olidm_pkg::VALUE_W-1:0] value;
  logic [olidm_pkg::POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface olidm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [olidm_pkg::STATUS_W-1:0]       status;
  logic signed [olidm_pkg::AVG_W-1:0]   average_scaled;
  logic [olidm_pkg::COUNT_OUT_W-1:0]    element_count;

  modport source (output valid, status, average_scaled, element_count, input ready);
  modport sink   (input valid, status, average_scaled, element_count, output ready);
endinterface

// File: rtl/core/olidm_ctrl.sv
// Controller state machine sequencing list moves, division and the response.
module olidm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  olidm_pkg::stat_t stat_i,
  output olidm_pkg::cmd_t  cmd_o
);

  olidm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olidm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      olidm_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = olidm_pkg::ST_DECODE;
      end
      olidm_pkg::ST_DECODE: begin
        case (stat_i.func)
          olidm_pkg::FUNC_INSERT: begin
            if (stat_i.pos_zero || stat_i.full) state_d = olidm_pkg::ST_RESP;
            else state_d = olidm_pkg::ST_SHIFT;
          end
          olidm_pkg::FUNC_DELETE: begin
            if (stat_i.pos_zero || stat_i.pos_beyond) state_d = olidm_pkg::ST_RESP;
            else state_d = olidm_pkg::ST_SHIFT;
          end
          olidm_pkg::FUNC_AVERAGE: begin
            if (stat_i.empty) state_d = olidm_pkg::ST_RESP;
            else state_d = olidm_pkg::ST_DIV;
          end
          default: state_d = olidm_pkg::ST_RESP;
        endcase
      end
      olidm_pkg::ST_SHIFT: begin
        if (stat_i.shift_done) begin
          if (stat_i.func == olidm_pkg::FUNC_INSERT) state_d = olidm_pkg::ST_INS_FIN;
          else state_d = olidm_pkg::ST_DEL_FIN;
        end
      end
      olidm_pkg::ST_INS_FIN: state_d = olidm_pkg::ST_RESP;
      olidm_pkg::ST_DEL_FIN: state_d = olidm_pkg::ST_RESP;
      olidm_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = olidm_pkg::ST_ROUND;
      end
      olidm_pkg::ST_ROUND: state_d = olidm_pkg::ST_SAT;
      olidm_pkg::ST_SAT:   state_d = olidm_pkg::ST_RESP;
      olidm_pkg::ST_RESP: begin
        if (!stat_i.out_busy) state_d = olidm_pkg::ST_IDLE;
      end
      default: state_d = olidm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      olidm_pkg::ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      olidm_pkg::ST_DECODE: begin
        case (stat_i.func)
          olidm_pkg::FUNC_INSERT: begin
            if (stat_i.pos_zero) begin
              cmd_o.status_we   = 1'b1;
              cmd_o.status_code = olidm_pkg::STATUS_IGNORED;
            end else if (stat_i.full) begin
              cmd_o.status_we   = 1'b1;
              cmd_o.status_code = olidm_pkg::STATUS_FULL;
            end else begin
              cmd_o.setup_ins = 1'b1;
            end
          end
          olidm_pkg::FUNC_DELETE: begin
            if (stat_i.pos_zero || stat_i.pos_beyond) begin
              cmd_o.status_we   = 1'b1;
              cmd_o.status_code = olidm_pkg::STATUS_IGNORED;
            end else begin
              cmd_o.setup_del = 1'b1;
            end
          end
          olidm_pkg::FUNC_AVERAGE: begin
            if (stat_i.empty) begin
              cmd_o.status_we   = 1'b1;
              cmd_o.status_code = olidm_pkg::STATUS_EMPTY;
            end else begin
              cmd_o.div_start = 1'b1;
            end
          end
          default: begin
            cmd_o.status_we   = 1'b1;
            cmd_o.status_code = olidm_pkg::STATUS_IGNORED;
          end
        endcase
      end
      olidm_pkg::ST_SHIFT:   cmd_o.shift    = 1'b1;
      olidm_pkg::ST_INS_FIN: cmd_o.ins_fin  = 1'b1;
      olidm_pkg::ST_DEL_FIN: cmd_o.del_fin  = 1'b1;
      olidm_pkg::ST_DIV:     cmd_o.div_step = 1'b1;
      olidm_pkg::ST_ROUND:   cmd_o.round    = 1'b1;
      olidm_pkg::ST_SAT:     cmd_o.sat      = 1'b1;
      olidm_pkg::ST_RESP:    cmd_o.respond  = !stat_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/core/olidm_dpath.sv
// Datapath: entry memory, count, running sum, serial divider and response register.
module olidm_dpath #(
  parameter int unsigned CAPACITY      = olidm_pkg::CAPACITY_DEF,
  parameter int unsigned FRACTION_BITS = olidm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  olidm_pkg::cmd_t                       cmd_i,
  output olidm_pkg::stat_t                      stat_o,
  input  logic [olidm_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [olidm_pkg::VALUE_W-1:0]  value_i,
  input  logic [olidm_pkg::POS_W-1:0]           position_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [olidm_pkg::STATUS_W-1:0]        status_o,
  output logic signed [olidm_pkg::AVG_W-1:0]    average_scaled_o,
  output logic [olidm_pkg::COUNT_OUT_W-1:0]     element_count_o
);

  localparam int unsigned VW    = olidm_pkg::VALUE_W;
  localparam int unsigned PW    = olidm_pkg::POS_W;
  localparam int unsigned AVW   = olidm_pkg::AVG_W;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned SUM_W = VW + CNT_W;
  localparam int unsigned QW    = SUM_W + FRACTION_BITS;
  localparam int unsigned DCW   = $clog2(QW);
  localparam int unsigned XW    = (QW + 1 > AVW + 1) ? QW + 1 : AVW + 1;
  localparam int unsigned CMP_W = (CNT_W > PW) ? CNT_W : PW;

  // request and list state
  logic [olidm_pkg::FUNC_W-1:0] func_q;
  logic signed [VW-1:0]         value_q;
  logic [PW-1:0]                pos_q;
  logic [CNT_W-1:0]             count_q, count_d;
  logic signed [SUM_W-1:0]      sum_q, sum_d;

  // move sequencer
  logic [AW-1:0]    slot_q, idx_q, pend_addr_q;
  logic [CNT_W-1:0] rem_q;
  logic             pend_q;

  // entry memory
  logic signed [VW-1:0] mem [CAPACITY];
  logic signed [VW-1:0] rdata_q;
  logic                 mem_we, rd_en;
  logic [AW-1:0]        mem_wa;
  logic signed [VW-1:0] mem_wd;

  // divider
  logic [CNT_W-1:0] dr_q;
  logic [QW-1:0]    dq_q;
  logic [DCW-1:0]   dcnt_q;
  logic             neg_q;
  logic [QW:0]      qr_q;

  // result
  logic [olidm_pkg::STATUS_W-1:0] status_q;
  logic signed [AVW-1:0]          avg_q;
  logic                           out_valid_q;
  logic [olidm_pkg::STATUS_W-1:0] out_status_q;
  logic signed [AVW-1:0]          out_avg_q;
  logic [olidm_pkg::COUNT_OUT_W-1:0] out_cnt_q;

  logic          is_ins, pos_beyond, drop_first;
  logic [AW-1:0] ins_slot, del_slot;
  logic [SUM_W-1:0] sum_neg, sum_mag;
  logic [CNT_W:0]   trial, diff, cnt_ext;
  logic             ge, round_up;
  logic [XW-1:0]    qx, qx_neg;
  logic signed [AVW-1:0] avg_sat;

  assign is_ins     = (func_q == olidm_pkg::FUNC_INSERT);
  assign pos_beyond = CMP_W'(pos_q) > CMP_W'(count_q);
  assign ins_slot   = pos_beyond ? AW'(count_q) : AW'(pos_q - PW'(1));
  assign del_slot   = AW'(pos_q - PW'(1));
  assign drop_first = !is_ins && (pend_addr_q == slot_q);

  assign stat_o.func       = func_q;
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.pos_beyond = pos_beyond;
  assign stat_o.full       = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.shift_done = (rem_q == '0) && !pend_q;
  assign stat_o.div_last   = (dcnt_q == '0);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign rd_en  = cmd_i.shift && (rem_q != '0);
  assign mem_we = cmd_i.ins_fin || (cmd_i.shift && pend_q && !drop_first);
  assign mem_wa = cmd_i.ins_fin ? slot_q :
                  (is_ins ? pend_addr_q + AW'(1) : pend_addr_q - AW'(1));
  assign mem_wd = cmd_i.ins_fin ? value_q : rdata_q;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (cmd_i.ins_fin) begin
      sum_d   = sum_q + SUM_W'(value_q);
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.del_fin) begin
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.shift && pend_q && drop_first) begin
      sum_d = sum_q - SUM_W'(rdata_q);
    end
  end

  assign sum_neg  = SUM_W'(0) - sum_q;
  assign sum_mag  = sum_q[SUM_W-1] ? sum_neg : sum_q;
  assign cnt_ext  = {1'b0, count_q};
  assign trial    = {dr_q, dq_q[QW-1]};
  assign ge       = trial >= cnt_ext;
  assign diff     = trial - cnt_ext;
  assign round_up = {dr_q, 1'b0} >= cnt_ext;

  assign qx     = XW'(qr_q);
  assign qx_neg = XW'(0) - qx;
  always_comb begin
    if (neg_q) begin
      avg_sat = (qx > XW'(olidm_pkg::AVG_MIN)) ? olidm_pkg::AVG_MIN : qx_neg[AVW-1:0];
    end else begin
      avg_sat = (qx > XW'(olidm_pkg::AVG_MAX)) ? olidm_pkg::AVG_MAX : qx[AVW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      if (cmd_i.setup_ins || cmd_i.setup_del) pend_q <= 1'b0;
      else if (cmd_i.shift) pend_q <= rd_en;
      if (cmd_i.respond) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q   <= func_i;
      value_q  <= value_i;
      pos_q    <= position_i;
      status_q <= olidm_pkg::STATUS_DONE;
      avg_q    <= '0;
    end
    if (cmd_i.status_we) status_q <= cmd_i.status_code;
    if (cmd_i.setup_ins) begin
      slot_q <= ins_slot;
      idx_q  <= AW'(count_q) - AW'(1);
      rem_q  <= count_q - CNT_W'(ins_slot);
    end
    if (cmd_i.setup_del) begin
      slot_q <= del_slot;
      idx_q  <= del_slot;
      rem_q  <= count_q - CNT_W'(del_slot);
    end
    if (rd_en) begin
      idx_q       <= is_ins ? idx_q - AW'(1) : idx_q + AW'(1);
      rem_q       <= rem_q - CNT_W'(1);
      pend_addr_q <= idx_q;
    end
    if (cmd_i.div_start) begin
      neg_q  <= sum_q[SUM_W-1];
      dr_q   <= '0;
      dq_q   <= {sum_mag, {FRACTION_BITS{1'b0}}};
      dcnt_q <= DCW'(QW - 1);
    end
    if (cmd_i.div_step) begin
      dr_q   <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dq_q   <= {dq_q[QW-2:0], ge};
      dcnt_q <= dcnt_q - DCW'(1);
    end
    if (cmd_i.round) qr_q <= {1'b0, dq_q} + (QW+1)'(round_up);
    if (cmd_i.sat) avg_q <= avg_sat;
    if (cmd_i.respond) begin
      out_status_q <= status_q;
      out_avg_q    <= avg_q;
      out_cnt_q    <= olidm_pkg::COUNT_OUT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rdata_q <= mem[idx_q];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign average_scaled_o = out_avg_q;
  assign element_count_o  = out_cnt_q;

endmodule

// File: rtl/core/ordered_list_insert_delete_mean.sv
// Top level of the ordered list with positional insert, delete and mean.
//
//   channel  dir  fields                                   request taken when
//   req_i    in   func, value, position                    valid && ready
//   rsp_o    out  status, average_scaled, element_count    valid && ready
//
// Insert and delete shift the entries behind the position, an append none;
// the entry memory moves one word per cycle. Requests that change nothing go
// straight to the response. Average divides the running sum by the count in
// the one-bit-per-cycle divider. A new request is taken while a response
// still waits in the output register; a stalled response holds the next one
// back. After reset the list is empty and the first request is taken at once.
module ordered_list_insert_delete_mean #(
  parameter int unsigned CAPACITY      = olidm_pkg::CAPACITY_DEF,
  parameter int unsigned FRACTION_BITS = olidm_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  olidm_req_if.sink    req_i,
  olidm_rsp_if.source  rsp_o
);

  olidm_pkg::cmd_t  cmd;
  olidm_pkg::stat_t stat;

  olidm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  olidm_dpath #(
    .CAPACITY      (CAPACITY),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .func_i           (req_i.func),
    .value_i          (req_i.value),
    .position_i       (req_i.position),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .status_o         (rsp_o.status),
    .average_scaled_o (rsp_o.average_scaled),
    .element_count_o  (rsp_o.element_count)
  );

endmodule
